// File: hdl/gpsm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the gamepad poll serial master.
// No dependencies; every other file in hdl/ imports this package.
package gpsm_pkg;

  localparam int unsigned NUM_BYTES  = 9;
  localparam int unsigned BYTE_IDX_W = 4;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP = 2'd1;

  localparam logic [TICK_W-1:0] HALF_BIT_RESET = 16'd50;
  localparam logic [TICK_W-1:0] BYTE_GAP_RESET = 16'd500;

  // Command bytes
  localparam logic [7:0] CMD_START = 8'h01;
  localparam logic [7:0] CMD_POLL  = 8'h42;
  localparam logic [7:0] CMD_IDLE  = 8'h00;

  // Reply header bytes
  localparam logic [7:0] REPLY_HDR     = 8'hff;
  localparam logic [7:0] REPLY_DIGITAL = 8'h41;
  localparam logic [7:0] REPLY_ANALOG  = 8'h73;
  localparam logic [7:0] REPLY_ACK     = 8'h5a;

  // Mode codes
  localparam logic [1:0] MODE_FAILED  = 2'd0;
  localparam logic [1:0] MODE_DIGITAL = 2'd1;
  localparam logic [1:0] MODE_ANALOG  = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] half_bit_ticks;
    logic [TICK_W-1:0] byte_gap_ticks;
  } gpsm_cfg_t;

  typedef struct packed {
    logic        select_n;
    logic        clock_pin;
    logic        data_out;
    logic        done_res;
    logic [1:0]  mode_status;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } gpsm_res_t;

  function automatic logic [7:0] cmd_byte(input logic [BYTE_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = CMD_START;
      4'd1:    b = CMD_POLL;
      default: b = CMD_IDLE;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/gpsm_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: half-bit length and byte gap length.
// Depends on gpsm_pkg.
module gpsm_cfg
  import gpsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output gpsm_cfg_t             cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_bit_ticks <= HALF_BIT_RESET;
      cfg.byte_gap_ticks <= BYTE_GAP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HALF_BIT: cfg.half_bit_ticks <= cfg_data;
        CFG_BYTE_GAP: cfg.byte_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/gpsm_core.sv
`timescale 1ns / 1ps
// Poll sequencer: phase, tick and bit counters, reply byte store and the
// per-tick pin and result logic. Depends on gpsm_pkg.
module gpsm_core
  import gpsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      start_req,
  input  logic      data_in,
  input  gpsm_cfg_t cfg,
  output gpsm_res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_GAP  = 3'd1,
    PH_LOW  = 3'd2,
    PH_HIGH = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  phase_t                phase, phase_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic [BYTE_IDX_W-1:0] byte_index, byte_index_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_in, shift_in_next;
  logic [7:0]            reply_bytes [NUM_BYTES];

  logic [BYTE_IDX_W-1:0] bidx;
  logic [7:0]            cmd;
  logic                  cbit;
  logic [TICK_W:0]       tick_inc;
  logic [TICK_W-1:0]     half_len;
  logic                  half_end;
  logic                  gap_end;
  logic                  reply_we;
  logic [7:0]            shift_upd;
  logic                  last_byte_next;
  logic [BYTE_IDX_W-1:0] byte_inc;

  assign bidx      = (byte_index < BYTE_IDX_W'(NUM_BYTES)) ? byte_index : '0;
  assign cmd       = cmd_byte(bidx);
  assign cbit      = cmd[bit_index];
  assign tick_inc  = {1'b0, tick_count} + 17'd1;
  assign half_len  = (cfg.half_bit_ticks == '0) ? 16'd1 : cfg.half_bit_ticks;
  assign half_end  = tick_inc >= {1'b0, half_len};
  assign gap_end   = tick_inc >= {1'b0, cfg.byte_gap_ticks};
  assign shift_upd = (tick_count == '0) ? (shift_in | (8'(data_in) << bit_index)) : shift_in;
  assign byte_inc  = byte_index + 4'd1;
  assign last_byte_next = byte_inc >= BYTE_IDX_W'(NUM_BYTES);

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    byte_index_next = byte_index;
    bit_index_next  = bit_index;
    shift_in_next   = shift_in;
    reply_we        = 1'b0;
    res             = '0;
    res.select_n    = 1'b1;
    res.clock_pin   = 1'b1;
    res.data_out    = 1'b1;

    unique case (phase)
      PH_GAP: begin
        res.select_n = 1'b0;
        res.data_out = (byte_index == '0);
        if (gap_end) begin
          tick_count_next = '0;
          phase_next = (byte_index >= BYTE_IDX_W'(NUM_BYTES)) ? PH_DONE : PH_LOW;
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_LOW: begin
        res.select_n  = 1'b0;
        res.clock_pin = 1'b0;
        res.data_out  = cbit;
        if (half_end) begin
          tick_count_next = '0;
          phase_next      = PH_HIGH;
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_HIGH: begin
        res.select_n  = 1'b0;
        res.data_out  = cbit;
        shift_in_next = shift_upd;
        if (half_end) begin
          tick_count_next = '0;
          if (bit_index == 3'd7) begin
            reply_we        = 1'b1;
            shift_in_next   = '0;
            bit_index_next  = '0;
            byte_index_next = byte_inc;
            // Enter the gap, or skip it when its length is zero
            if (cfg.byte_gap_ticks == '0) begin
              phase_next = last_byte_next ? PH_DONE : PH_LOW;
            end else begin
              phase_next = PH_GAP;
            end
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_LOW;
          end
        end else begin
          tick_count_next = tick_inc[TICK_W-1:0];
        end
      end
      PH_DONE: begin
        res.done_res = 1'b1;
        if (reply_bytes[0] == REPLY_HDR && reply_bytes[2] == REPLY_ACK) begin
          if (reply_bytes[1] == REPLY_DIGITAL) begin
            res.mode_status = MODE_DIGITAL;
          end else if (reply_bytes[1] == REPLY_ANALOG) begin
            res.mode_status = MODE_ANALOG;
          end else begin
            res.mode_status = MODE_FAILED;
          end
        end else begin
          res.mode_status = MODE_FAILED;
        end
        res.buttons     = ~{reply_bytes[4], reply_bytes[3]};
        res.right_x     = reply_bytes[5];
        res.right_y     = reply_bytes[6];
        res.left_x      = reply_bytes[7];
        res.left_y      = reply_bytes[8];
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        byte_index_next = '0;
        bit_index_next  = '0;
        shift_in_next   = '0;
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          byte_index_next = '0;
          bit_index_next  = '0;
          shift_in_next   = '0;
          tick_count_next = '0;
          phase_next      = (cfg.byte_gap_ticks == '0) ? PH_LOW : PH_GAP;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      byte_index <= '0;
      bit_index  <= '0;
      shift_in   <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      byte_index <= byte_index_next;
      bit_index  <= bit_index_next;
      shift_in   <= shift_in_next;
    end
  end

  // Reply store: written once per byte, read in the done tick
  always_ff @(posedge clk) begin
    if (step && reply_we) begin
      reply_bytes[bidx] <= shift_upd;
    end
  end

endmodule

// File: hdl/gpsm_outreg.sv
`timescale 1ns / 1ps
// Output register stage with valid/ready toward the consumer.
// Depends on gpsm_pkg.
module gpsm_outreg
  import gpsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  gpsm_res_t res_in,
  output logic      hold_free,
  output logic      out_valid,
  input  logic      out_ready,
  output gpsm_res_t res_out
);

  assign hold_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// File: hdl/gamepad_poll_serial_master_top.sv
`timescale 1ns / 1ps
// Gamepad poll serial master, top level.
// The result of each input transfer is loaded into the output register.
// Throughput: one input tick per cycle while the output register is empty or draining; it frees each cycle it drains.
// Reset (rst, synchronous): sequencer idle, half bit 50 and byte gap 500 ticks,
// output register empty. Reply bytes are not reset; every one is written before use.
module gamepad_poll_serial_master_top
  import gpsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tick input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  start_req,
  input  logic                  data_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  select_n,
  output logic                  clock_pin,
  output logic                  data_out,
  output logic                  done_res,
  output logic [1:0]            mode_status,
  output logic [15:0]           buttons,
  output logic [7:0]            right_x,
  output logic [7:0]            right_y,
  output logic [7:0]            left_x,
  output logic [7:0]            left_y,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  gpsm_cfg_t cfg;
  gpsm_res_t res_now;
  gpsm_res_t res_q;
  logic      hold_free;
  logic      step;

  // Take a tick whenever the output register is empty or draining this cycle
  assign in_ready = hold_free;
  assign step     = in_valid && in_ready;

  gpsm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: advance one tick per accepted input transfer
  gpsm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .start_req (start_req),
    .data_in   (data_in),
    .cfg       (cfg),
    .res       (res_now)
  );

  // Hold the pin levels and poll result until the consumer takes the transfer
  gpsm_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_now),
    .hold_free (hold_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign select_n    = res_q.select_n;
  assign clock_pin   = res_q.clock_pin;
  assign data_out    = res_q.data_out;
  assign done_res    = res_q.done_res;
  assign mode_status = res_q.mode_status;
  assign buttons     = res_q.buttons;
  assign right_x     = res_q.right_x;
  assign right_y     = res_q.right_y;
  assign left_x      = res_q.left_x;
  assign left_y      = res_q.left_y;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for gamepad_poll_serial_master_top: one tick per input transfer,
// a cycle-accurate poll predictor, and a field-by-field check of every result transfer.
// Depends on hdl/gpsm_pkg.sv and hdl/gamepad_poll_serial_master_top.sv.
module testbench;
  import gpsm_pkg::*;

  // Leave a wide margin over the slowest expected run.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned NUM_DIRECTED  = 20;

  // Sequencer phases of the poll, mirrored in the predictor.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_GAP,
    SEQ_LOW,
    SEQ_HIGH,
    SEQ_DONE
  } seq_phase_e;

  // One directed tick: inputs, and a hand-written result where one is given.
  typedef struct packed {
    logic      start;
    logic      din;
    logic      typed;
    gpsm_res_t pins;
  } tick_row_t;

  // Pin levels: select, clock and data high when idle; select low, data high
  // in the gap before the first byte. Every result field is zero.
  localparam gpsm_res_t IDLE_PINS = {4'b1110, 50'h0};
  localparam gpsm_res_t GAP0_PINS = {4'b0110, 50'h0};
  localparam gpsm_res_t NO_PINS   = '0;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  start_req;
  logic                  data_in;
  logic                  out_valid;
  logic                  out_ready;
  logic                  select_n;
  logic                  clock_pin;
  logic                  data_out;
  logic                  done_res;
  logic [1:0]            mode_status;
  logic [15:0]           buttons;
  logic [7:0]            right_x;
  logic [7:0]            right_y;
  logic [7:0]            left_x;
  logic [7:0]            left_y;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: sequencer, received bytes and the register copies.
  seq_phase_e  seq_phase;
  logic [15:0] seq_ticks;
  logic [3:0]  seq_byte;
  logic [2:0]  seq_bit;
  logic [7:0]  seq_shift;
  logic [7:0]  reply_seen [NUM_BYTES];
  logic [15:0] half_ticks;
  logic [15:0] gap_ticks;

  // Reply the emulated controller sends during the current poll.
  logic [7:0]  reply_plan [NUM_BYTES];

  gpsm_res_t   pending_pins [$];
  tick_row_t   directed_rows [NUM_DIRECTED];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycles;

  gamepad_poll_serial_master_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Leave the idle gap: go on to the next byte, or to the done tick after nine.
  function automatic void close_gap();
    seq_ticks = '0;
    seq_phase = (seq_byte >= NUM_BYTES) ? SEQ_DONE : SEQ_LOW;
  endfunction

  // Enter the idle gap; a zero gap length skips it in the same tick.
  function automatic void open_gap();
    seq_ticks = '0;
    if (gap_ticks == 0) close_gap();
    else seq_phase = SEQ_GAP;
  endfunction

  // Advance the poll by one tick and return the pins and result of that tick.
  function automatic gpsm_res_t pins_for_tick(input logic start, input logic din);
    gpsm_res_t   p;
    logic [3:0]  slot;
    logic [7:0]  cmd;
    int unsigned half;
    p    = IDLE_PINS;
    slot = (seq_byte < NUM_BYTES) ? seq_byte : '0;
    cmd  = (slot == 0) ? CMD_START : (slot == 1) ? CMD_POLL : CMD_IDLE;
    // A zero half bit behaves like one tick.
    half = (half_ticks == 0) ? 1 : half_ticks;
    case (seq_phase)
      SEQ_GAP: begin
        p.select_n = 1'b0;
        // Data stays high only before the first byte; every command ends in 0.
        p.data_out = (seq_byte == 0);
        if (seq_ticks + 1 >= gap_ticks) close_gap();
        else seq_ticks = seq_ticks + 1'b1;
      end
      SEQ_LOW: begin
        p.select_n  = 1'b0;
        p.clock_pin = 1'b0;
        p.data_out  = cmd[seq_bit];
        if (seq_ticks + 1 >= half) begin
          seq_ticks = '0;
          seq_phase = SEQ_HIGH;
        end else begin
          seq_ticks = seq_ticks + 1'b1;
        end
      end
      SEQ_HIGH: begin
        p.select_n = 1'b0;
        p.data_out = cmd[seq_bit];
        // Sample the controller on the first clock-high tick only.
        if (seq_ticks == 0) seq_shift[seq_bit] = seq_shift[seq_bit] | din;
        if (seq_ticks + 1 >= half) begin
          seq_ticks = '0;
          if (seq_bit == 3'd7) begin
            reply_seen[slot] = seq_shift;
            seq_shift        = '0;
            seq_bit          = '0;
            seq_byte         = seq_byte + 1'b1;
            open_gap();
          end else begin
            seq_bit   = seq_bit + 1'b1;
            seq_phase = SEQ_LOW;
          end
        end else begin
          seq_ticks = seq_ticks + 1'b1;
        end
      end
      SEQ_DONE: begin
        p.done_res    = 1'b1;
        p.mode_status = MODE_FAILED;
        if (reply_seen[0] == REPLY_HDR && reply_seen[2] == REPLY_ACK) begin
          if (reply_seen[1] == REPLY_DIGITAL) p.mode_status = MODE_DIGITAL;
          else if (reply_seen[1] == REPLY_ANALOG) p.mode_status = MODE_ANALOG;
        end
        p.buttons = ~{reply_seen[4], reply_seen[3]};
        p.right_x = reply_seen[5];
        p.right_y = reply_seen[6];
        p.left_x  = reply_seen[7];
        p.left_y  = reply_seen[8];
        // A start in the done tick is dropped; the next poll starts from idle.
        seq_phase = SEQ_IDLE;
        seq_ticks = '0;
        seq_byte  = '0;
        seq_bit   = '0;
        seq_shift = '0;
      end
      default: begin
        seq_phase = SEQ_IDLE;
        if (start) begin
          seq_byte  = '0;
          seq_bit   = '0;
          seq_shift = '0;
          open_gap();
        end
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Controller emulation
  // ---------------------------------------------------------------------------

  // Byte with extra weight on all-zero and all-one.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Plan a reply: mostly a valid digital or analog header, sometimes a
  // damaged header, sometimes nothing but noise.
  function automatic void plan_reply();
    int unsigned kind;
    kind = $urandom_range(9);
    reply_plan[0] = REPLY_HDR;
    reply_plan[1] = (kind < 4) ? REPLY_DIGITAL : REPLY_ANALOG;
    reply_plan[2] = REPLY_ACK;
    for (int i = 3; i < NUM_BYTES; i++) reply_plan[i] = pick_byte();
    if (kind == 7 || kind == 8) begin
      reply_plan[$urandom_range(2)] = pick_byte();
    end else if (kind == 9) begin
      for (int i = 0; i < 3; i++) reply_plan[i] = pick_byte();
    end
  endfunction

  // Data pin for the next tick: the planned reply bit on a sample tick,
  // random noise on every other tick.
  function automatic logic next_din();
    if (seq_phase == SEQ_HIGH && seq_ticks == 0) return reply_plan[seq_byte][seq_bit];
    return 1'($urandom_range(1));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Transfer one tick, then predict it. A typed row overrides the prediction
  // with the hand-written result, but still advances the predictor.
  task automatic drive_tick(input logic start, input logic din, input logic typed,
                            input gpsm_res_t typed_pins);
    logic      was_idle;
    gpsm_res_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= start;
    data_in   <= din;
    do @(posedge clk); while (!in_ready);
    was_idle  = (seq_phase == SEQ_IDLE);
    predicted = pins_for_tick(start, din);
    pending_pins.push_back(typed ? typed_pins : predicted);
    // Pick the controller's reply as soon as a poll is taken.
    if (was_idle && start) plan_reply();
  endtask

  // Run ticks until the sequencer is back in idle.
  task automatic finish_poll();
    while (seq_phase != SEQ_IDLE) drive_tick(1'($urandom_range(1)), next_din(), 1'b0, NO_PINS);
  endtask

  // Drop valid and hold until every predicted result has been checked.
  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pins.size() != 0);
  endtask

  // Write one register, then lower valid for a cycle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HALF_BIT) half_ticks = value;
    else gap_ticks = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One setting of the timing registers: idle the block, drain, reprogram,
  // then send random ticks. If allow_start, most request a poll, so starts
  // land while busy and in the done tick, and short polls run back to back.
  task automatic run_setting(input logic [15:0] half, input logic [15:0] gap,
                             input int unsigned count, input logic allow_start);
    finish_poll();
    hold_for_results();
    write_reg(CFG_HALF_BIT, half);
    write_reg(CFG_BYTE_GAP, gap);
    for (int k = 0; k < count; k++) begin
      // Hold mid-setting (and now and then at random) until the results drain.
      if (k == count / 2 || $urandom_range(199) == 0) hold_for_results();
      drive_tick(allow_start && ($urandom_range(3) != 0), next_din(), 1'b0, NO_PINS);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
    mismatches++;
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
  endfunction

  function automatic void check_pins(input gpsm_res_t want, input gpsm_res_t got);
    if (want.select_n !== got.select_n) note_mismatch("select_n", want.select_n, got.select_n);
    if (want.clock_pin !== got.clock_pin)
      note_mismatch("clock_pin", want.clock_pin, got.clock_pin);
    if (want.data_out !== got.data_out) note_mismatch("data_out", want.data_out, got.data_out);
    if (want.done_res !== got.done_res) note_mismatch("done_res", want.done_res, got.done_res);
    if (want.mode_status !== got.mode_status)
      note_mismatch("mode_status", want.mode_status, got.mode_status);
    if (want.buttons !== got.buttons) note_mismatch("buttons", want.buttons, got.buttons);
    if (want.right_x !== got.right_x) note_mismatch("right_x", want.right_x, got.right_x);
    if (want.right_y !== got.right_y) note_mismatch("right_y", want.right_y, got.right_y);
    if (want.left_x !== got.left_x) note_mismatch("left_x", want.left_x, got.left_x);
    if (want.left_y !== got.left_y) note_mismatch("left_y", want.left_y, got.left_y);
  endfunction

  // Check each result transfer against the oldest prediction, and stall the
  // result channel at random.
  always @(posedge clk) begin
    gpsm_res_t seen;
    gpsm_res_t want;
    seen = {select_n, clock_pin, data_out, done_res, mode_status, buttons,
            right_x, right_y, left_x, left_y};
    if (!rst && out_valid && out_ready) begin
      if (pending_pins.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none actual %0h", $time, seen);
      end else begin
        want = pending_pins.pop_front();
        check_pins(want, seen);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    start_req <= 1'b0;
    data_in   <= 1'b0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_HALF_BIT;
    cfg_data  <= '0;
    mismatches    = 0;
    cycles        = 0;
    send_idle_pct = 37;
    recv_idle_pct = 74;

    // Predictor reset state, register defaults included.
    seq_phase  = SEQ_IDLE;
    seq_ticks  = '0;
    seq_byte   = '0;
    seq_bit    = '0;
    seq_shift  = '0;
    half_ticks = HALF_BIT_RESET;
    gap_ticks  = BYTE_GAP_RESET;
    for (int i = 0; i < NUM_BYTES; i++) reply_seen[i] = '0;
    plan_reply();

    // Directed ticks at the reset timing: idle pins, a start (its own tick
    // still shows idle), then the pre-byte gap with starts that must be ignored.
    directed_rows = '{
      {1'b0, 1'b0, 1'b1, IDLE_PINS},
      {1'b0, 1'b1, 1'b1, IDLE_PINS},
      {1'b1, 1'b1, 1'b1, IDLE_PINS},
      {1'b1, 1'b0, 1'b1, GAP0_PINS},
      {1'b0, 1'b1, 1'b1, GAP0_PINS},
      {1'b1, 1'b1, 1'b1, GAP0_PINS},
      {1'b0, 1'b0, 1'b0, NO_PINS},
      {1'b1, 1'b1, 1'b0, NO_PINS},
      {1'b0, 1'b1, 1'b0, NO_PINS},
      {1'b1, 1'b0, 1'b0, NO_PINS},
      {1'b0, 1'b0, 1'b0, NO_PINS},
      {1'b1, 1'b1, 1'b0, NO_PINS},
      {1'b0, 1'b1, 1'b0, NO_PINS},
      {1'b1, 1'b0, 1'b0, NO_PINS},
      {1'b0, 1'b0, 1'b0, NO_PINS},
      {1'b1, 1'b1, 1'b0, NO_PINS},
      {1'b0, 1'b1, 1'b0, NO_PINS},
      {1'b1, 1'b0, 1'b0, NO_PINS},
      {1'b0, 1'b0, 1'b0, NO_PINS},
      {1'b1, 1'b1, 1'b0, NO_PINS}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++)
      drive_tick(directed_rows[r].start, directed_rows[r].din, directed_rows[r].typed,
                 directed_rows[r].pins);
    // Drain, then shorten the timing inside the first gap so the rest of this
    // poll stays short; the gap ends on the next tick.
    hold_for_results();
    write_reg(CFG_HALF_BIT, 16'd1);
    write_reg(CFG_BYTE_GAP, 16'd2);
    finish_poll();

    // Sender idles lightly, receiver heavily. Zero gap included.
    run_setting(16'd1, 16'd0, 150, 1'b1);
    run_setting(16'd2, 16'd1, 100, 1'b1);

    // Sender idles heavily, receiver lightly. The all-ones setting would take
    // millions of ticks per poll, so only idle ticks run under it.
    send_idle_pct = 74;
    recv_idle_pct = 37;
    run_setting(16'hffff, 16'hffff, 24, 1'b0);
    run_setting(16'd1, 16'd3, 100, 1'b1);
    run_setting(16'd0, 16'd2, 100, 1'b1);

    // No idling on either side. Zero half bit with zero gap included.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_setting(16'd0, 16'd0, 100, 1'b1);
    run_setting(16'd1, 16'd1, 200, 1'b1);

    finish_poll();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/gpsm_pkg.sv
hdl/gpsm_cfg.sv
hdl/gpsm_core.sv
hdl/gpsm_outreg.sv
hdl/gamepad_poll_serial_master_top.sv
tb/testbench.sv
